// ===== rtl/mmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpt_pkg
// Shared types, field widths and codes for the min/max priority table.
// ----------------------------------------------------------------------------
package mmpt_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int ID_W            = 16;
   localparam int LVL_W           = 8;
   localparam int KEY_W           = LVL_W + ID_W;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [LVL_W-1:0] level;
      logic [ID_W-1:0]  id;
   } cell_data_type;

   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

   typedef struct packed {
      logic             hit;
      logic [LVL_W-1:0] hit_level;
      logic             full;
      logic             empty;
      logic [ID_W-1:0]  min_id;
      logic [ID_W-1:0]  max_id;
   } lookup_type;

   localparam cell_data_type EMPTY_CELL = '{valid: 1'b0, level: '0, id: '0};

endpackage

// ===== rtl/min_max_priority_table.sv =====
// ----------------------------------------------------------------------------
// min_max_priority_table
// Bounded (id, level) table with add, remove by id and min/max query.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries commands: tuser holds opcode and want_highest,
//   tdata holds item_id and item_level. rsp channel returns result_id in
//   tdata and status in tuser, one transaction per query and one per add
//   dropped on a full table; remove and other adds return nothing.
//   Entries sit in a chain of cells kept sorted by (level, id) and packed
//   toward cell 0, so the lowest entry is in cell 0 and the highest is the
//   last occupied cell. The id lookup and extremes are captured when a
//   transaction is accepted; the chain shifts in the following cycle.
//   An item steps through accept, then execute; an add whose id is already
//   present also steps through insert, as the old entry is shifted out
//   before the new one is shifted in. A result is registered in execute.
//   A pending result does not block the next accept; an item that needs
//   the output register holds in execute while the receiver stalls.
//   Reset empties every cell and the output register at once.
// ----------------------------------------------------------------------------
module min_max_priority_table #(
   parameter int ENTRIES = mmpt_pkg::ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // item_id[15:0], item_level[23:16]
   input  logic [2:0]  req_tuser,   // opcode[1:0], want_highest[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_id[15:0]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import mmpt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_INSERT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       op_ff;
   logic [ID_W-1:0]  id_ff;
   logic [LVL_W-1:0] level_ff;
   logic             high_ff;
   lookup_type       look_ff;
   lookup_type       look;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_load;
   logic             out_free;
   logic             req_fire;

   cell_cmd_type     cell_cmd;
   cell_data_type    cells      [ENTRIES];
   cell_data_type    left_data  [ENTRIES];
   cell_data_type    right_data [ENTRIES];
   logic             left_lt    [ENTRIES];
   logic             lt         [ENTRIES];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff | rsp_tready;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (i == 0) begin
            left_data[i] = EMPTY_CELL;
            left_lt[i]   = 1'b1;
         end else begin
            left_data[i] = cells[(i+ENTRIES-1) % ENTRIES];
            left_lt[i]   = lt[(i+ENTRIES-1) % ENTRIES];
         end
         if (i == ENTRIES-1) begin
            right_data[i] = EMPTY_CELL;
         end else begin
            right_data[i] = cells[(i+1) % ENTRIES];
         end
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      mmpt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .left_data  (left_data[g]),
         .left_lt    (left_lt[g]),
         .right_data (right_data[g]),
         .data       (cells[g]),
         .lt         (lt[g])
      );
   end

   mmpt_lookup #(
      .ENTRIES (ENTRIES)
   ) u_lookup (
      .cells   (cells),
      .find_id (req_tdata[15:0]),
      .result  (look)
   );

   always_comb begin
      state_in      = state_ff;
      cell_cmd      = '0;
      rsp_load      = 1'b0;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_ADD: begin
                  if (look_ff.hit) begin
                     cell_cmd.rem = 1'b1;
                     cell_cmd.key = {look_ff.hit_level, id_ff};
                     state_in     = ST_INSERT;
                  end else if (look_ff.full) begin
                     if (out_free) begin
                        rsp_load      = 1'b1;
                        rsp_id_in     = '0;
                        rsp_status_in = STATUS_FULL;
                        state_in      = ST_IDLE;
                     end
                  end else begin
                     cell_cmd.ins = 1'b1;
                     cell_cmd.key = {level_ff, id_ff};
                     state_in     = ST_IDLE;
                  end
               end
               OP_REMOVE: begin
                  if (look_ff.hit) begin
                     cell_cmd.rem = 1'b1;
                     cell_cmd.key = {look_ff.hit_level, id_ff};
                  end
                  state_in = ST_IDLE;
               end
               OP_QUERY: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     if (look_ff.empty) begin
                        rsp_id_in     = '0;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_id_in     = high_ff ? look_ff.max_id : look_ff.min_id;
                        rsp_status_in = STATUS_OK;
                     end
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_INSERT: begin
            cell_cmd.ins = 1'b1;
            cell_cmd.key = {level_ff, id_ff};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_tuser[1:0];
         high_ff  <= req_tuser[2];
         id_ff    <= req_tdata[15:0];
         level_ff <= req_tdata[23:16];
         look_ff  <= look;
      end
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   logic sorted_ok;

   always_comb begin
      sorted_ok = 1'b1;
      for (int i = 0; i < ENTRIES-1; i++) begin
         if (cells[i+1].valid && (!cells[i].valid ||
             {cells[i].level, cells[i].id} >= {cells[i+1].level, cells[i+1].id})) begin
            sorted_ok = 1'b0;
         end
      end
   end

   a_chain_sorted: assert property (@(posedge clock) disable iff (reset)
      sorted_ok)
      else $error("cell chain lost sorted packed order");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not enter execute");

   a_insert_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> ($past(state_ff) == ST_EXEC && op_ff == OP_ADD &&
                                   look_ff.hit))
      else $error("reinsert without a matching add");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_status_in == STATUS_FULL) |-> cells[ENTRIES-1].valid)
      else $error("add dropped while table has room");

   a_no_double_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cell_cmd.ins && cell_cmd.rem))
      else $error("insert and remove issued together");
`endif

endmodule

// ===== rtl/mmpt_cell.sv =====
// ----------------------------------------------------------------------------
// mmpt_cell
// One slot of the sorted chain; shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module mmpt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mmpt_pkg::cell_cmd_type cmd,
   input  mmpt_pkg::cell_data_type left_data,
   input  logic                   left_lt,
   input  mmpt_pkg::cell_data_type right_data,
   output mmpt_pkg::cell_data_type data,
   output logic                   lt
);
   import mmpt_pkg::*;

   cell_data_type data_ff;
   cell_data_type data_in;
   logic          below;

   assign below = ({data_ff.level, data_ff.id} < cmd.key);
   assign lt    = data_ff.valid & below;
   assign data  = data_ff;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (!lt) begin
            if (left_lt) begin
               data_in.valid = 1'b1;
               data_in.level = cmd.key[KEY_W-1:ID_W];
               data_in.id    = cmd.key[ID_W-1:0];
            end else begin
               data_in = left_data;
            end
         end
      end else if (cmd.rem) begin
         if (data_ff.valid && !below) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff.level <= data_in.level;
      data_ff.id    <= data_in.id;
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
   end

endmodule

// ===== rtl/mmpt_lookup.sv =====
// ----------------------------------------------------------------------------
// mmpt_lookup
// Id match, fill and extreme-entry reduction across the cell chain.
// ----------------------------------------------------------------------------
module mmpt_lookup #(
   parameter int ENTRIES = mmpt_pkg::ENTRIES_DEFAULT
) (
   input  mmpt_pkg::cell_data_type cells [ENTRIES],
   input  logic [mmpt_pkg::ID_W-1:0] find_id,
   output mmpt_pkg::lookup_type    result
);
   import mmpt_pkg::*;

   always_comb begin
      result           = '0;
      result.full      = cells[ENTRIES-1].valid;
      result.empty     = !cells[0].valid;
      result.min_id    = cells[0].id;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cells[i].valid && cells[i].id == find_id) begin
            result.hit       = 1'b1;
            result.hit_level = result.hit_level | cells[i].level;
         end
         if (i == ENTRIES-1) begin
            if (cells[i].valid) begin
               result.max_id = result.max_id | cells[i].id;
            end
         end else if (cells[i].valid && !cells[(i+1) % ENTRIES].valid) begin
            result.max_id = result.max_id | cells[i].id;
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_max_priority_table. A queue of pending
// commands feeds a stream driver; a scoreboard model of the (id, level)
// table predicts each query answer and each full-table drop at the moment
// a command transaction is accepted, and a monitor checks every response
// transaction against the oldest prediction. Both sides of the stream stall
// at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import mmpt_pkg::*;

   localparam int         TBL_DEPTH   = ENTRIES_DEFAULT;
   localparam int         NO_SLOT     = -1;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         DRAIN_GAP   = 8;
   localparam int         CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [1:0]       op;
      logic [ID_W-1:0]  id;
      logic [LVL_W-1:0] level;
      logic             hi;
   } cmd_item_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [1:0]      status;
   } rsp_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // item_id[15:0], item_level[23:16]
   logic [2:0]  req_tuser  = '0;   // opcode[1:0], want_highest[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // result_id[15:0]
   logic [1:0]  rsp_tuser;         // status[1:0]

   cmd_item_type pending_cmds[$];
   rsp_item_type expected_rsps[$];
   cmd_item_type cur_cmd;
   bit           cmd_taken   = 1'b0;

   bit               tbl_valid[TBL_DEPTH];
   logic [ID_W-1:0]  tbl_id[TBL_DEPTH];
   logic [LVL_W-1:0] tbl_level[TBL_DEPTH];

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_req     = 0;
   int hold_left    = 0;
   int n_pushed     = 0;
   int n_sent       = 0;
   int n_checked    = 0;
   int n_full       = 0;
   int n_empty      = 0;
   int err_count    = 0;
   int cycle_count  = 0;

   min_max_priority_table #(
      .ENTRIES(TBL_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int find_slot(input logic [ID_W-1:0] id);
      int s;
      s = NO_SLOT;
      for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_id[i] == id) s = i;
      end
      return s;
   endfunction

   function automatic int free_slot();
      int s;
      s = NO_SLOT;
      for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
         if (!tbl_valid[i]) s = i;
      end
      return s;
   endfunction

   function automatic bit outranks(input int a, input int b, input logic hi);
      if (tbl_level[a] != tbl_level[b]) begin
         return hi ? (tbl_level[a] > tbl_level[b]) : (tbl_level[a] < tbl_level[b]);
      end
      return hi ? (tbl_id[a] > tbl_id[b]) : (tbl_id[a] < tbl_id[b]);
   endfunction

   task automatic apply_cmd(input cmd_item_type c);
      int           s;
      int           best;
      rsp_item_type r;
      case (c.op)
         OP_ADD: begin
            s = find_slot(c.id);
            if (s == NO_SLOT) begin
               s = free_slot();
               if (s == NO_SLOT) begin
                  r.id     = '0;
                  r.status = STATUS_FULL;
                  expected_rsps.push_back(r);
                  n_full++;
               end else begin
                  tbl_valid[s] = 1'b1;
                  tbl_id[s]    = c.id;
                  tbl_level[s] = c.level;
               end
            end else begin
               tbl_level[s] = c.level;
            end
         end
         OP_REMOVE: begin
            s = find_slot(c.id);
            if (s != NO_SLOT) tbl_valid[s] = 1'b0;
         end
         OP_QUERY: begin
            best = NO_SLOT;
            for (int i = 0; i < TBL_DEPTH; i++) begin
               if (tbl_valid[i] && (best == NO_SLOT || outranks(i, best, c.hi))) best = i;
            end
            if (best == NO_SLOT) begin
               r.id     = '0;
               r.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               r.id     = tbl_id[best];
               r.status = STATUS_OK;
            end
            expected_rsps.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_err(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // drive command transactions
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || cmd_taken) begin
         cmd_taken = 1'b0;
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
            cur_cmd = pending_cmds.pop_front();
            req_tdata  <= {cur_cmd.level, cur_cmd.id};
            req_tuser  <= {cur_cmd.hi, cur_cmd.op};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver backpressure, with a counted long hold-off on request
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // sample both channels
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_cmd(cur_cmd);
            cmd_taken = 1'b1;
            n_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               report_err($sformatf("unexpected response id=%0h status=%0d",
                                    rsp_tdata, rsp_tuser));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata !== want.id)
                  report_err($sformatf("result_id %0h, expected %0h", rsp_tdata, want.id));
               if (rsp_tuser !== want.status)
                  report_err($sformatf("status %0d, expected %0d", rsp_tuser, want.status));
               n_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [ID_W-1:0] pool_id(input int k);
      return (k < 40) ? ID_W'(k) : ID_W'(16'hFFFF - (k - 40));
   endfunction

   function automatic logic [LVL_W-1:0] rand_level();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return LVL_W'($urandom_range(0, 3));
      if (r == 4) return LVL_W'($urandom_range(252, 255));
      return LVL_W'($urandom_range(0, 255));
   endfunction

   task automatic push_cmd(input logic [1:0] op, input logic [ID_W-1:0] id,
                           input logic [LVL_W-1:0] level, input logic hi);
      cmd_item_type c;
      c.op    = op;
      c.id    = id;
      c.level = level;
      c.hi    = hi;
      pending_cmds.push_back(c);
      n_pushed++;
   endtask

   task automatic wait_drain();
      while (n_sent != n_pushed || expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic gen_random(input int count);
      int         done_n;
      int         mode;
      int         seg;
      int         add_w;
      int         rem_w;
      int         p;
      logic [1:0] op;
      logic [ID_W-1:0] id;
      done_n = 0;
      mode   = 1;
      seg    = 0;
      while (done_n < count) begin
         if (seg == 0) begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(20, 60);
         end
         seg--;
         add_w = (mode == 0) ? 75 : (mode == 1) ? 40 : 15;
         rem_w = (mode == 0) ? 10 : (mode == 1) ? 30 : 55;
         id = ($urandom_range(0, 99) < 85) ? pool_id($urandom_range(0, 79))
                                           : ID_W'($urandom);
         if ($urandom_range(0, 99) < 3) begin
            op = OP_UNUSED;
         end else begin
            p = $urandom_range(0, 99);
            if (p < add_w)              op = OP_ADD;
            else if (p < add_w + rem_w) op = OP_REMOVE;
            else                        op = OP_QUERY;
            done_n++;
         end
         push_cmd(op, id, rand_level(), 1'($urandom_range(0, 1)));
      end
   endtask

   // fill to capacity, overflow, update in place while full
   task automatic fill_burst();
      for (int k = 0; k < 70; k++) push_cmd(OP_ADD, pool_id(k), rand_level(), 1'b0);
      push_cmd(OP_QUERY, 16'h0000, 8'h00, 1'b1);
      push_cmd(OP_QUERY, 16'hFFFF, 8'hFF, 1'b0);
      push_cmd(OP_ADD, pool_id(0), 8'hFF, 1'b1);
      push_cmd(OP_ADD, 16'hABCD, 8'h55, 1'b0);
      push_cmd(OP_QUERY, 16'h5A5A, 8'hA5, 1'b1);
      push_cmd(OP_QUERY, 16'hA5A5, 8'h5A, 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      snd_idle_pct = 15;
      rcv_idle_pct = 81;
      // empty table, then ties at both extremes, update in place, removes
      push_cmd(OP_QUERY,  16'h0000, 8'h00, 1'b0);
      push_cmd(OP_QUERY,  16'hFFFF, 8'hFF, 1'b1);
      push_cmd(OP_REMOVE, 16'h1234, 8'hFF, 1'b1);
      push_cmd(OP_ADD,    16'h0000, 8'h00, 1'b0);
      push_cmd(OP_ADD,    16'hFFFF, 8'hFF, 1'b1);
      push_cmd(OP_ADD,    16'h1234, 8'hFF, 1'b0);
      push_cmd(OP_ADD,    16'h0001, 8'h00, 1'b1);
      push_cmd(OP_QUERY,  16'h0000, 8'h00, 1'b1);
      push_cmd(OP_QUERY,  16'hFFFF, 8'hFF, 1'b0);
      push_cmd(OP_ADD,    16'h0000, 8'hC8, 1'b0);
      push_cmd(OP_QUERY,  16'h0000, 8'h00, 1'b0);
      push_cmd(OP_REMOVE, 16'hFFFF, 8'h00, 1'b0);
      push_cmd(OP_QUERY,  16'h0000, 8'h00, 1'b1);
      push_cmd(OP_REMOVE, 16'hFFFF, 8'h00, 1'b0);
      push_cmd(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1);
      push_cmd(OP_UNUSED, 16'h0000, 8'h00, 1'b0);
      push_cmd(OP_QUERY,  16'h0000, 8'h00, 1'b1);
      push_cmd(OP_REMOVE, 16'h0000, 8'h00, 1'b0);
      push_cmd(OP_REMOVE, 16'h0001, 8'h00, 1'b0);
      push_cmd(OP_REMOVE, 16'h1234, 8'h00, 1'b0);
      push_cmd(OP_QUERY,  16'h0000, 8'h00, 1'b0);
      push_cmd(OP_QUERY,  16'h0000, 8'h00, 1'b1);
      wait_drain();
      gen_random(120);
      fill_burst();
      gen_random(100);
      wait_drain();

      snd_idle_pct = 81;
      rcv_idle_pct = 15;
      gen_random(100);
      fill_burst();
      gen_random(100);
      wait_drain();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_req = 400;
      for (int k = 0; k < 60; k++) begin
         if (k % 2 == 0)
            push_cmd(OP_QUERY, ID_W'($urandom), rand_level(), 1'($urandom_range(0, 1)));
         else
            push_cmd(OP_ADD, pool_id($urandom_range(0, 79)), rand_level(), 1'b0);
      end
      wait_drain();
      gen_random(120);
      wait_drain();

      if (expected_rsps.size() != 0)
         report_err($sformatf("%0d responses never arrived", expected_rsps.size()));
      $display("Sent %0d commands (add, remove, query, unused code) over three stall mixes.",
               n_sent);
      $display("Checked %0d responses: %0d full-table drops, %0d empty queries.",
               n_checked, n_full, n_empty);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
